// ----- rtl/bfs_pkg.sv -----
package bfs_pkg;

  // Ring geometry.
  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths and limits of one transfer.
  localparam int MAX_RES = 16;
  localparam int POP_W   = 5;
  localparam int OCC_W   = 5;
  localparam int POS_W   = 6;
  localparam int SAT_MAX = 31;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ACT_ENQ     = 3'd0,
    ACT_DEQ     = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_REPLACE = 3'd4,
    ACT_CLEAR   = 3'd5,
    ACT_LIST    = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic signed [POS_W-1:0] POS_NONE = -6'sd1;

  typedef struct packed {
    logic [7:0]              item;
    status_e                 status;
    logic signed [POS_W-1:0] position;
    logic [OCC_W-1:0]        occupancy;
    logic                    is_empty;
    logic                    is_full;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic       we;
    idx_t       waddr;
    logic [7:0] wdata;
    idx_t       raddr;
  } ram_req_t;

  // Physical slot of the entry that sits off places behind the head.
  function automatic idx_t slot_f(idx_t head, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic idx_t next_head_f(idx_t head);
    idx_t nh;
    nh = (head == idx_t'(DEPTH - 1)) ? '0 : head + idx_t'(1);
    return nh;
  endfunction

  // One-based search position, saturated.
  function automatic logic signed [POS_W-1:0] pos_f(cnt_t idx);
    logic [CNT_W:0] n;
    n = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
    if (32'(n) > 32'(SAT_MAX)) begin
      return POS_W'(SAT_MAX);
    end
    return POS_W'(n);
  endfunction

  function automatic logic [OCC_W-1:0] occ_f(cnt_t cnt);
    if (32'(cnt) > 32'(SAT_MAX)) begin
      return OCC_W'(SAT_MAX);
    end
    return OCC_W'(cnt);
  endfunction

endpackage

// ----- rtl/byte_fifo_with_search_top.sv -----
// Sequence: enqueue, replace, clear and every empty-queue result pass through S_EXEC and
// then S_EMIT; a peek or a dequeue of a held entry passes S_EXEC, S_READ and S_EMIT.
// Search visits S_EXEC and S_READ for each entry inspected, then S_EMIT on a hit, or
// S_EXEC and S_EMIT on a miss. List passes S_EXEC, S_READ and S_EMIT for each entry.
// Throughput: one item at a time, the next is taken once its last result is registered.
// Reset clears the head, the fill count, the sequencer and the output valid flag; the
// byte ring itself is not cleared and only written entries are ever read.
module byte_fifo_with_search_top
  import bfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] value, [12:8] pop_count, [15:13] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] item, [9:8] status, [15:10] position,
                                      // [20:16] occupancy, [21] is_empty, [22] is_full,
                                      // [23] zero
  output logic        m_axis_tlast    // last result caused by one input transfer
);

  // The sequencer walks the ring one entry at a time through a single read port
  // whose data is registered, so every read passes through the S_READ state.
  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic       res_valid;
  logic       slot_free;
  result_t    res;

  // Output register, freed as soon as the downstream side takes the transfer.
  logic        out_valid_q;
  result_t     out_q;

  assign slot_free = !out_valid_q || m_axis_tready;

  bfs_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  bfs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .value_i     (s_axis_tdata[7:0]),
    .pop_count_i (s_axis_tdata[12:8]),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (slot_free),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The payload needs no reset; it is qualified by the valid flag.
  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {1'b0, out_q.is_full, out_q.is_empty, out_q.occupancy,
                          out_q.position, out_q.status, out_q.item};

endmodule

// ----- rtl/bfs_ring.sv -----
module bfs_ring
  import bfs_pkg::*;
(
  input  logic       clk_i,
  input  ram_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bfs_seq.sv -----
module bfs_seq
  import bfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic [7:0] value_i,
  input  logic [POP_W-1:0] pop_count_i,
  output ram_req_t   ram_req_o,
  input  logic [7:0] ram_rdata_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  action_e           act_q, act_d;
  logic [7:0]        val_q, val_d;
  logic [POP_W-1:0]  rem_q, rem_d;
  cnt_t              idx_q, idx_d;
  idx_t              head_q, head_d;
  cnt_t              count_q, count_d;
  result_t           res_q, res_d;
  logic              empty, full;
  logic [CNT_W:0]    idx_inc;
  logic [POP_W-1:0]  pops_sat;

  assign empty   = (count_q == '0);
  assign full    = (count_q == cnt_t'(DEPTH));
  assign idx_inc = (CNT_W+1)'(idx_q) + (CNT_W+1)'(1);

  always_comb begin
    pops_sat = pop_count_i;
    if (pop_count_i == '0) begin
      pops_sat = POP_W'(1);
    end else if (32'(pop_count_i) > 32'(MAX_RES)) begin
      pops_sat = POP_W'(MAX_RES);
    end
  end

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    val_d   = val_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    head_d  = head_q;
    count_d = count_q;
    res_d   = res_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = slot_f(head_q, count_q);
    ram_req_o.wdata = val_q;
    ram_req_o.raddr = (act_q == ACT_DEQ || act_q == ACT_PEEK) ? head_q
                                                              : slot_f(head_q, idx_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_e'(action_i);
          val_d   = value_i;
          rem_d   = pops_sat;
          idx_d   = '0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d          = '0;
        res_d.status   = ST_OK;
        res_d.last     = 1'b1;
        state_d        = S_EMIT;
        case (act_q)
          ACT_ENQ: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              ram_req_o.we = 1'b1;
              count_d      = count_q + cnt_t'(1);
            end
          end
          ACT_DEQ: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
              res_d.last   = (rem_q == POP_W'(1));
              rem_d        = rem_q - POP_W'(1);
            end else begin
              state_d = S_READ;
            end
          end
          ACT_PEEK, ACT_LIST: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else begin
              state_d = S_READ;
            end
          end
          ACT_SEARCH: begin
            if (idx_q == count_q) begin
              res_d.position = POS_NONE;
            end else begin
              state_d = S_READ;
            end
          end
          ACT_REPLACE: begin
            if (empty) begin
              res_d.status = ST_EMPTY;
            end else begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = slot_f(head_q, count_q - cnt_t'(1));
            end
          end
          ACT_CLEAR: begin
            head_d  = '0;
            count_d = '0;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_READ: begin
        state_d = S_EMIT;
        case (act_q)
          ACT_DEQ: begin
            res_d.item = ram_rdata_i;
            res_d.last = (rem_q == POP_W'(1));
            rem_d      = rem_q - POP_W'(1);
            head_d     = next_head_f(head_q);
            count_d    = count_q - cnt_t'(1);
          end
          ACT_SEARCH: begin
            if (ram_rdata_i == val_q) begin
              res_d.position = pos_f(idx_q);
            end else begin
              idx_d   = cnt_t'(idx_inc);
              state_d = S_EXEC;
            end
          end
          ACT_LIST: begin
            res_d.item = ram_rdata_i;
            res_d.last = (idx_inc == (CNT_W+1)'(count_q)) ||
                         (32'(idx_inc) == 32'(MAX_RES));
            idx_d      = cnt_t'(idx_inc);
          end
          default: begin
            res_d.item = ram_rdata_i;
          end
        endcase
      end

      S_EMIT: begin
        if (res_ready_i) begin
          state_d = res_q.last ? S_IDLE : S_EXEC;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      act_q   <= ACT_ENQ;
      rem_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      act_q   <= act_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);

  always_comb begin
    res_o           = res_q;
    res_o.occupancy = occ_f(count_q);
    res_o.is_empty  = empty;
    res_o.is_full   = full;
  end

endmodule

// ----- rtl/bfs_chk.sv -----
module bfs_chk
  import bfs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // The empty flag agrees with the reported occupancy.
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21] == (m_axis_tdata[20:16] == '0)))
    else $error("empty flag disagrees with occupancy");

  // The full flag agrees with the reported occupancy.
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[22] == (m_axis_tdata[20:16] == OCC_W'(DEPTH))))
    else $error("full flag disagrees with occupancy");

  // A refused enqueue is only reported while the queue is full.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9:8] == ST_FULL) |-> m_axis_tdata[22])
    else $error("full status on a queue that is not full");

  // An accepted item keeps the input closed in the following cycle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened right after a transfer");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind byte_fifo_with_search_top bfs_chk u_bfs_chk (.*);
